[hdl/tvg_pkg.sv]
package tvg_pkg;

  localparam int IN_W  = 16;   // ring 6 + tube 5, padded to bytes
  localparam int OUT_W = 144;  // 139 bits of vertex, padded to bytes

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PIH_Q30 = 64'd1686629713;  // pi/2, Q1.30
  localparam longint POS_LIMIT = 131072;

  // register codes, taken from paddr[2]
  localparam logic REG_MAJOR = 1'b0;
  localparam logic REG_MINOR = 1'b1;

  // one table entry: texture coordinate and cos/sin in Q1.30
  typedef struct packed {
    logic [16:0]        tex_q;
    logic signed [31:0] cos_q;
    logic signed [31:0] sin_q;
  } trig_ent_t;

  // two new factors of a Taylor term, before the factorial divide
  function automatic longint unsigned tstep(input longint unsigned t, input longint unsigned x);
    longint unsigned p;
    p = (t * x) >> 30;
    return (p * x) >> 30;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input longint s);
    if (s > longint'(ONE_Q30)) return 32'(ONE_Q30);
    if (s < -longint'(ONE_Q30)) return -32'(ONE_Q30);
    return 32'(s);
  endfunction

  function automatic logic signed [31:0] cos_series(input longint unsigned x);
    longint unsigned t;
    longint s;
    t = ONE_Q30;
    s = longint'(t);
    t = tstep(t, x) / 2;   s = s - longint'(t);
    t = tstep(t, x) / 12;  s = s + longint'(t);
    t = tstep(t, x) / 30;  s = s - longint'(t);
    t = tstep(t, x) / 56;  s = s + longint'(t);
    t = tstep(t, x) / 90;  s = s - longint'(t);
    t = tstep(t, x) / 132; s = s + longint'(t);
    t = tstep(t, x) / 182; s = s - longint'(t);
    t = tstep(t, x) / 240; s = s + longint'(t);
    t = tstep(t, x) / 306; s = s - longint'(t);
    return clamp_q30(s);
  endfunction

  function automatic logic signed [31:0] sin_series(input longint unsigned x);
    longint unsigned t;
    longint s;
    t = x;
    s = longint'(t);
    t = tstep(t, x) / 6;   s = s - longint'(t);
    t = tstep(t, x) / 20;  s = s + longint'(t);
    t = tstep(t, x) / 42;  s = s - longint'(t);
    t = tstep(t, x) / 72;  s = s + longint'(t);
    t = tstep(t, x) / 110; s = s - longint'(t);
    t = tstep(t, x) / 156; s = s + longint'(t);
    t = tstep(t, x) / 210; s = s - longint'(t);
    t = tstep(t, x) / 272; s = s + longint'(t);
    t = tstep(t, x) / 342; s = s - longint'(t);
    return clamp_q30(s);
  endfunction

  // quadrant fold; result is {cos, sin}
  function automatic logic [63:0] quad_map(input logic [1:0] q, input longint unsigned x);
    logic signed [31:0] cx;
    logic signed [31:0] sx;
    cx = cos_series(x);
    sx = sin_series(x);
    case (q)
      2'd0:    return {cx, sx};
      2'd1:    return {-sx, cx};
      2'd2:    return {-cx, -sx};
      default: return {sx, -cx};
    endcase
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int unsigned s);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (s - 1);
    mag  = (v < 0) ? 64'(-v) : 64'(v);
    mag  = (mag + half) >> s;
    return (v < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [18:0] clamp_pos(input logic signed [63:0] v);
    if (v > POS_LIMIT) return 19'(POS_LIMIT);
    if (v < -POS_LIMIT) return 19'(-POS_LIMIT);
    return 19'(v);
  endfunction

endpackage

[hdl/torus_vertex_generator.sv]
// Torus vertex generator: one grid cell in, two triangle-strip vertices out.
// Slave stream: s_tdata carries ring_index and tube_index; one beat per cell.
// Master stream: two beats per cell, the vertex on ring i first (tuser/tlast
// low), then the vertex on ring i+1 (tuser/tlast high). Each beat holds
// texture coordinates, position and unit normal in fixed point.
// APB port: major_radius at 0x0, minor_radius at 0x4 (Q4.12, low 16 bits);
// change them only while no vertex is in flight.
// The input stage S0 holds each cell and splits it into two vertex beats, the
// vertex on ring i first; it takes a new cell as the held one sends its second
// beat. The five-stage datapath then takes one vertex per cycle while m_tready
// is high (lookup, radius multiply, round, angle multiply, round and clamp).
// Angle tables are constants built at elaboration from the segment counts.
// Reset empties all stages and loads the default radii (1.0 and 0.5); no
// clearing pass is needed. When m_tready is low the pipeline holds; bubbles
// still close up, and s_tready drops once the stages are full, so nothing is
// lost or repeated.
module torus_vertex_generator #(
  parameter int MAJOR_SEGMENTS = 50,
  parameter int MINOR_SEGMENTS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // cell input
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tvg_pkg::IN_W-1:0]   s_tdata,   // ring_index[5:0], tube_index[10:6]
  // vertex output
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [tvg_pkg::OUT_W-1:0]  m_tdata,   // tex_u, tex_v, pos_x, pos_y, pos_z,
                                                // norm_x, norm_y, norm_z, zero pad
  output logic                       m_tuser,   // which_ring
  output logic                       m_tlast
);

  // ---------------------------------------------------------------------
  // Elaboration-time tables
  // ---------------------------------------------------------------------
  // Ring table keyed by {ring_index, which_ring}: the reduction of the ring
  // and the wrap of the last ring back to angle zero are folded in here.
  function automatic tvg_pkg::trig_ent_t maj_entry(input logic [6:0] key);
    longint unsigned rg;
    longint unsigned k;
    longint unsigned q;
    longint unsigned e;
    longint unsigned x;
    tvg_pkg::trig_ent_t ent;
    rg = (longint'(key[6:1]) % MAJOR_SEGMENTS) + longint'(key[0]);
    ent.tex_q = 17'((2 * rg * 65536 + MAJOR_SEGMENTS) / (2 * MAJOR_SEGMENTS));
    k = rg % MAJOR_SEGMENTS;
    q = (4 * k) / MAJOR_SEGMENTS;
    e = 4 * k - q * MAJOR_SEGMENTS;
    x = (2 * e * tvg_pkg::PIH_Q30 + MAJOR_SEGMENTS) / (2 * MAJOR_SEGMENTS);
    {ent.cos_q, ent.sin_q} = tvg_pkg::quad_map(q[1:0], x);
    return ent;
  endfunction

  // Tube table keyed by raw tube_index: saturation at the last step included
  function automatic tvg_pkg::trig_ent_t min_entry(input logic [4:0] key);
    longint unsigned ts;
    longint unsigned k;
    longint unsigned q;
    longint unsigned e;
    longint unsigned x;
    tvg_pkg::trig_ent_t ent;
    ts = (longint'(key) > MINOR_SEGMENTS) ? longint'(MINOR_SEGMENTS) : longint'(key);
    ent.tex_q = 17'((2 * ts * 65536 + MINOR_SEGMENTS) / (2 * MINOR_SEGMENTS));
    k = ts % MINOR_SEGMENTS;
    q = (4 * k) / MINOR_SEGMENTS;
    e = 4 * k - q * MINOR_SEGMENTS;
    x = (2 * e * tvg_pkg::PIH_Q30 + MINOR_SEGMENTS) / (2 * MINOR_SEGMENTS);
    {ent.cos_q, ent.sin_q} = tvg_pkg::quad_map(q[1:0], x);
    return ent;
  endfunction

  tvg_pkg::trig_ent_t maj_tab [128];
  tvg_pkg::trig_ent_t min_tab [32];

  for (genvar g = 0; g < 128; g++) begin : g_maj
    localparam tvg_pkg::trig_ent_t ENT = maj_entry(7'(g));
    assign maj_tab[g] = ENT;
  end

  for (genvar g = 0; g < 32; g++) begin : g_min
    localparam tvg_pkg::trig_ent_t ENT = min_entry(5'(g));
    assign min_tab[g] = ENT;
  end

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] major_radius;
  logic [15:0] minor_radius;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius <= 16'd4096;
      minor_radius <= 16'd2048;
    end else if (cfg_wr) begin
      if (paddr[2] == tvg_pkg::REG_MAJOR) major_radius <= pwdata[15:0];
      if (paddr[2] == tvg_pkg::REG_MINOR) minor_radius <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == tvg_pkg::REG_MINOR) ? {16'd0, minor_radius}
                                                   : {16'd0, major_radius};

  // ---------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------
  // S0: cell holder, splits a cell into two vertex beats
  logic v0, ph0;
  logic [5:0] ring0;
  logic [4:0] tube0;
  // S1: table lookup
  logic v1, w1;
  tvg_pkg::trig_ent_t ea1, eb1;
  // S2: radius and normal products
  logic v2, w2;
  logic signed [31:0] ca2, sa2;
  logic [16:0] tu2, tv2;
  logic signed [48:0] mcb2, msb2;
  logic signed [63:0] nxp2, nyp2;
  logic signed [15:0] nz2;
  // S3: ring radius and rounding
  logic v3, w3;
  logic signed [31:0] ca3, sa3, r3;
  logic [16:0] tu3, tv3;
  logic signed [18:0] pz3;
  logic signed [15:0] nx3, ny3, nz3;
  // S4: position products
  logic v4, w4;
  logic [16:0] tu4, tv4;
  logic signed [63:0] pxp4, pyp4;
  logic signed [18:0] pz4;
  logic signed [15:0] nx4, ny4, nz4;
  // S5: output register
  logic v5, w5;
  logic [16:0] tu5, tv5;
  logic signed [18:0] px5, py5, pz5;
  logic signed [15:0] nx5, ny5, nz5;

  // a stage loads when it is empty or its contents move on
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_acc;

  assign rdy5 = !v5 || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  // a new cell is taken as the held one sends its second beat
  assign s_tready = !v0 || (rdy1 && ph0);
  assign in_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      ph0 <= 1'b0;
    end else if (in_acc) begin
      v0  <= 1'b1;
      ph0 <= 1'b0;
    end else if (v0 && rdy1) begin
      if (ph0) begin
        v0 <= 1'b0;
      end else begin
        ph0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring0 <= s_tdata[5:0];
      tube0 <= s_tdata[10:6];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // datapath
  logic signed [16:0] minor_s;
  logic signed [63:0] rsum;

  assign minor_s = $signed({1'b0, minor_radius});
  assign rsum    = 64'(mcb2) + $signed({18'd0, major_radius, 30'd0});

  always_ff @(posedge clk) begin
    if (rdy1) begin
      w1  <= ph0;
      ea1 <= maj_tab[{ring0, ph0}];
      eb1 <= min_tab[tube0];
    end
    if (rdy2) begin
      w2   <= w1;
      ca2  <= ea1.cos_q;
      sa2  <= ea1.sin_q;
      tu2  <= ea1.tex_q;
      tv2  <= eb1.tex_q;
      mcb2 <= 49'(minor_s) * 49'(eb1.cos_q);
      msb2 <= 49'(minor_s) * 49'(eb1.sin_q);
      nxp2 <= 64'(ea1.cos_q) * 64'(eb1.cos_q);
      nyp2 <= 64'(ea1.sin_q) * 64'(eb1.cos_q);
      nz2  <= 16'(tvg_pkg::rnd_shift(64'(eb1.sin_q), 16));
    end
    if (rdy3) begin
      w3  <= w2;
      ca3 <= ca2;
      sa3 <= sa2;
      tu3 <= tu2;
      tv3 <= tv2;
      r3  <= 32'(tvg_pkg::rnd_shift(rsum, 18));
      pz3 <= tvg_pkg::clamp_pos(tvg_pkg::rnd_shift(64'(msb2), 30));
      nx3 <= 16'(tvg_pkg::rnd_shift(nxp2, 46));
      ny3 <= 16'(tvg_pkg::rnd_shift(nyp2, 46));
      nz3 <= nz2;
    end
    if (rdy4) begin
      w4   <= w3;
      tu4  <= tu3;
      tv4  <= tv3;
      pxp4 <= 64'(ca3) * 64'(r3);
      pyp4 <= 64'(sa3) * 64'(r3);
      pz4  <= pz3;
      nx4  <= nx3;
      ny4  <= ny3;
      nz4  <= nz3;
    end
    if (rdy5) begin
      w5  <= w4;
      tu5 <= tu4;
      tv5 <= tv4;
      px5 <= tvg_pkg::clamp_pos(tvg_pkg::rnd_shift(pxp4, 42));
      py5 <= tvg_pkg::clamp_pos(tvg_pkg::rnd_shift(pyp4, 42));
      pz5 <= pz4;
      nx5 <= nx4;
      ny5 <= ny4;
      nz5 <= nz4;
    end
  end

  assign m_tvalid = v5;
  assign m_tuser  = w5;
  assign m_tlast  = w5;
  assign m_tdata  = {5'd0, nz5, ny5, nx5, pz5, py5, px5, tv5, tu5};

`ifndef SYNTHESIS
  // no new cell while the held one still owes its second vertex
  a_hold_cell: assert property (@(posedge clk) disable iff (rst)
    (v0 && !ph0) |-> !s_tready)
    else $error("cell taken before second vertex was sent");

  // u reaches one only on the far ring of the last cell
  a_tex_wrap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[16]) |-> m_tuser)
    else $error("tex_u wrapped on the near ring");

  // normal x and y components stay within unit range
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[106:91]) >= -16384 && $signed(m_tdata[106:91]) <= 16384
              && $signed(m_tdata[122:107]) >= -16384 && $signed(m_tdata[122:107]) <= 16384))
    else $error("normal component out of range");
`endif

endmodule
